@@ hdl/owdm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owdm_pkg
// Shared types and constants of the one-way delay median estimator.
// ----------------------------------------------------------------------------
package owdm_pkg;

  // Microseconds in one second.
  localparam int unsigned US_PER_SEC = 1000000;

  // Fixed field widths of the item ports.
  localparam int unsigned SEC_BITS     = 32;
  localparam int unsigned MICRO_BITS   = 20;
  localparam int unsigned OUT_BITS     = 32;
  localparam int unsigned HELD_BITS    = 4;

  // Absolute time: 32-bit seconds times one million plus a 20-bit part.
  localparam int unsigned PROD_BITS    = SEC_BITS + MICRO_BITS;
  localparam int unsigned TIME_BITS    = PROD_BITS + 1;

  // Timestamp and difference slots.
  localparam logic [1:0] TS_SEND    = 2'd0;
  localparam logic [1:0] TS_REMOTE  = 2'd1;
  localparam logic [1:0] TS_ARRIVAL = 2'd2;

  localparam logic [1:0] DLY_RTT = 2'd0;
  localparam logic [1:0] DLY_FWD = 2'd1;
  localparam logic [1:0] DLY_REV = 2'd2;

  // Control that the sequencer sends along the row of sort cells.
  typedef struct packed {
    logic ins;
    logic shift;
  } owdm_cell_ctrl_t;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CONV  = 8'b0000_0010,
    S_DIFF  = 8'b0000_0100,
    S_CHECK = 8'b0000_1000,
    S_MDIV  = 8'b0001_0000,
    S_INS   = 8'b0010_0000,
    S_SCAN  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } owdm_state_e;

endpackage

@@ hdl/one_way_delay_median_estimator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_way_delay_median_estimator_top
// One-way delay estimator with drift correction and a windowed lower median.
// ----------------------------------------------------------------------------
// Each accepted item runs through timestamp conversion, the differences,
// a check, the drift scaling when forward plus reverse exceeds the round
// trip, insertion and the median scan; the next item is taken after the
// result is registered. The three timestamps are converted one per cycle
// on a single constant multiplier, the differences formed one per cycle,
// and the drift scaling runs in two bit-serial multiply-divide lanes that
// retire one bit of the round trip per cycle. The forward delays live
// sorted in a row of WINDOW_SAMPLES cells; a new value is inserted into
// all cells at once and the median is shifted out of the row toward cell
// zero, one cell per cycle.
// ----------------------------------------------------------------------------
module one_way_delay_median_estimator_top
  import owdm_pkg::*;
#(
  parameter int unsigned WINDOW_SAMPLES = 10,
  parameter int unsigned DELAY_BITS     = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [SEC_BITS-1:0]   send_seconds_i,
  input  logic [MICRO_BITS-1:0] send_micros_i,
  input  logic [SEC_BITS-1:0]   remote_seconds_i,
  input  logic [MICRO_BITS-1:0] remote_micros_i,
  input  logic [SEC_BITS-1:0]   arrival_seconds_i,
  input  logic [MICRO_BITS-1:0] arrival_micros_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_BITS-1:0]   round_trip_us_o,
  output logic [OUT_BITS-1:0]   forward_us_o,
  output logic [OUT_BITS-1:0]   reverse_us_o,
  output logic [OUT_BITS-1:0]   median_forward_us_o,
  output logic [HELD_BITS-1:0]  samples_held_o,
  output logic                  window_full_o,
  output logic                  saturated_o
);

  localparam int unsigned CNT_BITS = $clog2(WINDOW_SAMPLES + 1);
  localparam int unsigned BIT_W    = $clog2(DELAY_BITS);

  owdm_state_e state_q, state_d;

  // Captured input item.
  logic [SEC_BITS-1:0]   sec_q   [3];
  logic [MICRO_BITS-1:0] micro_q [3];

  logic [TIME_BITS-1:0]  t_q   [3];
  logic [DELAY_BITS-1:0] dly_q [3];
  logic [DELAY_BITS:0]   sum_q;
  logic                  clip_q;
  logic                  scale_q;

  logic [1:0]            idx_q;
  logic [BIT_W-1:0]      bit_q;
  logic [CNT_BITS-1:0]   cnt_q;
  logic [CNT_BITS-1:0]   scn_q;
  logic                  out_valid_q;

  logic [OUT_BITS-1:0]   rtt_out_q, fwd_out_q, rev_out_q, med_out_q;
  logic [HELD_BITS-1:0]  held_q;
  logic                  full_q, sat_q;

  logic                  accept;
  logic                  out_free;
  logic [PROD_BITS-1:0]  prod;
  logic [TIME_BITS-1:0]  t_new;
  logic [TIME_BITS-1:0]  da, db, dabs;
  logic                  over;
  logic [DELAY_BITS-1:0] dsat;
  logic [DELAY_BITS:0]   sum;
  logic [DELAY_BITS-1:0] q_fwd, q_rev, fwd_c, rev_c;
  logic [CNT_BITS-1:0]   cnt_eff;
  owdm_cell_ctrl_t       ctrl;

  logic                  gt  [WINDOW_SAMPLES];
  logic [DELAY_BITS-1:0] val [WINDOW_SAMPLES];
  logic [DELAY_BITS-1:0] rd  [WINDOW_SAMPLES];

  logic [OUT_BITS+DELAY_BITS-1:0] ext_rtt, ext_fwd, ext_rev, ext_med;
  logic [HELD_BITS+CNT_BITS-1:0]  ext_cnt;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // Timestamp conversion, one per cycle.
  assign prod  = PROD_BITS'(sec_q[idx_q]) * PROD_BITS'(US_PER_SEC);
  assign t_new = TIME_BITS'(prod) + TIME_BITS'(micro_q[idx_q]);

  // Absolute differences, one per cycle, saturated to the delay width.
  always_comb begin
    case (idx_q)
      DLY_RTT: begin
        da = t_q[TS_ARRIVAL];
        db = t_q[TS_SEND];
      end
      DLY_FWD: begin
        da = t_q[TS_REMOTE];
        db = t_q[TS_SEND];
      end
      default: begin
        da = t_q[TS_ARRIVAL];
        db = t_q[TS_REMOTE];
      end
    endcase
    dabs = (da >= db) ? (da - db) : (db - da);
    over = |dabs[TIME_BITS-1:DELAY_BITS];
    dsat = over ? '1 : dabs[DELAY_BITS-1:0];
  end

  // The reverse delay lands on the edge into the check state, so the check
  // compares against the sum of the current delays.
  assign sum     = {1'b0, dly_q[DLY_FWD]} + {1'b0, dly_q[DLY_REV]};
  assign fwd_c   = scale_q ? q_fwd : dly_q[DLY_FWD];
  assign rev_c   = scale_q ? q_rev : dly_q[DLY_REV];
  assign cnt_eff = (cnt_q >= CNT_BITS'(WINDOW_SAMPLES)) ? '0 : cnt_q;

  assign ctrl.ins   = (state_q == S_INS);
  assign ctrl.shift = (state_q == S_SCAN);

  owdm_muldiv #(.W(DELAY_BITS)) u_mdiv_fwd (
    .clk_i   (clk_i),
    .start_i (state_q == S_CHECK),
    .step_i  (state_q == S_MDIV),
    .a_i     (dly_q[DLY_FWD]),
    .d_i     (sum_q),
    .b_bit_i (dly_q[DLY_RTT][bit_q]),
    .q_o     (q_fwd)
  );

  owdm_muldiv #(.W(DELAY_BITS)) u_mdiv_rev (
    .clk_i   (clk_i),
    .start_i (state_q == S_CHECK),
    .step_i  (state_q == S_MDIV),
    .a_i     (dly_q[DLY_REV]),
    .d_i     (sum_q),
    .b_bit_i (dly_q[DLY_RTT][bit_q]),
    .q_o     (q_rev)
  );

  for (genvar i = 0; i < WINDOW_SAMPLES; i++) begin : g_cell
    logic                  left_gt;
    logic [DELAY_BITS-1:0] left_val;
    logic [DELAY_BITS-1:0] right_rd;

    if (i == 0) begin : g_first
      assign left_gt  = 1'b0;
      assign left_val = '0;
    end else begin : g_inner
      assign left_gt  = gt[i-1];
      assign left_val = val[i-1];
    end

    if (i == WINDOW_SAMPLES - 1) begin : g_last
      assign right_rd = '0;
    end else begin : g_body
      assign right_rd = rd[i+1];
    end

    owdm_cell #(
      .DATA_BITS (DELAY_BITS),
      .CNT_BITS  (CNT_BITS),
      .IDX       (i)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .cnt_i      (cnt_eff),
      .new_val_i  (fwd_c),
      .left_gt_i  (left_gt),
      .left_val_i (left_val),
      .right_rd_i (right_rd),
      .gt_o       (gt[i]),
      .val_o      (val[i]),
      .rd_o       (rd[i])
    );
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_CONV;
      S_CONV:  if (idx_q == TS_ARRIVAL) state_d = S_DIFF;
      S_DIFF:  if (idx_q == DLY_REV) state_d = S_CHECK;
      S_CHECK: state_d = ({1'b0, dly_q[DLY_RTT]} < sum) ? S_MDIV : S_INS;
      S_MDIV:  if (bit_q == '0) state_d = S_INS;
      S_INS:   state_d = ((cnt_eff >> 1) == '0) ? S_DONE : S_SCAN;
      S_SCAN:  if (scn_q == CNT_BITS'(1)) state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      bit_q       <= '0;
      scn_q       <= '0;
      cnt_q       <= '0;
      clip_q      <= 1'b0;
      scale_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          idx_q  <= '0;
          clip_q <= 1'b0;
        end
        S_CONV: begin
          idx_q <= (idx_q == TS_ARRIVAL) ? '0 : idx_q + 2'd1;
        end
        S_DIFF: begin
          idx_q  <= idx_q + 2'd1;
          clip_q <= clip_q | over;
        end
        S_CHECK: begin
          scale_q <= ({1'b0, dly_q[DLY_RTT]} < sum);
          bit_q   <= BIT_W'(DELAY_BITS - 1);
        end
        S_MDIV: begin
          bit_q <= bit_q - BIT_W'(1);
        end
        S_INS: begin
          cnt_q <= cnt_eff + CNT_BITS'(1);
          scn_q <= cnt_eff >> 1;
        end
        S_SCAN: begin
          scn_q <= scn_q - CNT_BITS'(1);
        end
        default: begin
        end
      endcase
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sec_q[TS_SEND]      <= send_seconds_i;
      micro_q[TS_SEND]    <= send_micros_i;
      sec_q[TS_REMOTE]    <= remote_seconds_i;
      micro_q[TS_REMOTE]  <= remote_micros_i;
      sec_q[TS_ARRIVAL]   <= arrival_seconds_i;
      micro_q[TS_ARRIVAL] <= arrival_micros_i;
    end
    if (state_q == S_CONV) begin
      t_q[idx_q] <= t_new;
    end
    if (state_q == S_DIFF) begin
      dly_q[idx_q] <= dsat;
    end
    sum_q <= sum;
  end

  assign ext_rtt = {{OUT_BITS{1'b0}}, dly_q[DLY_RTT]};
  assign ext_fwd = {{OUT_BITS{1'b0}}, fwd_c};
  assign ext_rev = {{OUT_BITS{1'b0}}, rev_c};
  assign ext_med = {{OUT_BITS{1'b0}}, rd[0]};
  assign ext_cnt = {{HELD_BITS{1'b0}}, cnt_q};

  // Result register; the next item may be taken while this one waits.
  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      rtt_out_q <= ext_rtt[OUT_BITS-1:0];
      fwd_out_q <= ext_fwd[OUT_BITS-1:0];
      rev_out_q <= ext_rev[OUT_BITS-1:0];
      med_out_q <= ext_med[OUT_BITS-1:0];
      held_q    <= ext_cnt[HELD_BITS-1:0];
      full_q    <= (cnt_q == CNT_BITS'(WINDOW_SAMPLES));
      sat_q     <= clip_q;
    end
  end

  assign in_ready_o          = (state_q == S_IDLE);
  assign out_valid_o         = out_valid_q;
  assign round_trip_us_o     = rtt_out_q;
  assign forward_us_o        = fwd_out_q;
  assign reverse_us_o        = rev_out_q;
  assign median_forward_us_o = med_out_q;
  assign samples_held_o      = held_q;
  assign window_full_o       = full_q;
  assign saturated_o         = sat_q;

endmodule

@@ hdl/owdm_muldiv.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owdm_muldiv
// Bit-serial floor(a * b / d), one bit of b per cycle while step_i is high, most significant first.
// ----------------------------------------------------------------------------
module owdm_muldiv #(
  parameter int unsigned W = 32
) (
  input  logic         clk_i,
  input  logic         start_i,
  input  logic         step_i,
  input  logic [W-1:0] a_i,
  input  logic [W:0]   d_i,
  input  logic         b_bit_i,
  output logic [W-1:0] q_o
);

  logic [W:0]   r_q, r_d;
  logic [W-1:0] q_q, q_d;
  logic [W+2:0] t, d1, d2;
  logic [W:0]   q_sh;

  // With a <= d and r < d, 2r + a stays below 3d, so at most two subtractions.
  always_comb begin
    t    = {1'b0, r_q, 1'b0} + (b_bit_i ? {3'b0, a_i} : '0);
    d1   = {2'b0, d_i};
    d2   = {1'b0, d_i, 1'b0};
    q_sh = {q_q, 1'b0};
    if (t >= d2) begin
      r_d = (W + 1)'(t - d2);
      q_d = W'(q_sh + (W + 1)'(2));
    end else if (t >= d1) begin
      r_d = (W + 1)'(t - d1);
      q_d = W'(q_sh + (W + 1)'(1));
    end else begin
      r_d = t[W:0];
      q_d = q_sh[W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q <= '0;
      q_q <= '0;
    end else if (step_i) begin
      r_q <= r_d;
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

@@ hdl/owdm_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owdm_cell
// One cell of the sorted window row, with a readout tap that shifts toward
// cell zero.
// ----------------------------------------------------------------------------
module owdm_cell
  import owdm_pkg::*;
#(
  parameter int unsigned DATA_BITS = 32,
  parameter int unsigned CNT_BITS  = 4,
  parameter int unsigned IDX       = 0
) (
  input  logic                 clk_i,
  input  owdm_cell_ctrl_t      ctrl_i,
  input  logic [CNT_BITS-1:0]  cnt_i,
  input  logic [DATA_BITS-1:0] new_val_i,
  input  logic                 left_gt_i,
  input  logic [DATA_BITS-1:0] left_val_i,
  input  logic [DATA_BITS-1:0] right_rd_i,
  output logic                 gt_o,
  output logic [DATA_BITS-1:0] val_o,
  output logic [DATA_BITS-1:0] rd_o
);

  logic [DATA_BITS-1:0] val_q, val_d;
  logic [DATA_BITS-1:0] rd_q;
  logic                 occ;

  // An empty cell acts as if it held a value above every sample.
  always_comb begin
    occ  = CNT_BITS'(IDX) < cnt_i;
    gt_o = !occ || (val_q > new_val_i);
    if (!gt_o) begin
      val_d = val_q;
    end else if (left_gt_i) begin
      val_d = left_val_i;
    end else begin
      val_d = new_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins) begin
      val_q <= val_d;
      rd_q  <= val_d;
    end else if (ctrl_i.shift) begin
      rd_q  <= right_rd_i;
    end
  end

  assign val_o = val_q;
  assign rd_o  = rd_q;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// One-way delay median estimator testbench
// Sends probe timestamps to the estimator and checks every report against a
// built-in predictor. The predictor covers the microsecond differences,
// saturation, drift scaling and the windowed lower median. Both handshakes
// stall at random, except during one stretch with no stalls.
// ----------------------------------------------------------------------------
module testbench
  import owdm_pkg::*;
();

  localparam int unsigned WINDOW_SAMPLES = 10;
  localparam int unsigned DELAY_BITS     = 32;
  localparam logic [63:0] DELAY_MAX      = (64'd1 << DELAY_BITS) - 64'd1;
  localparam int unsigned SETTLE_CYCLES  = 64;
  localparam int unsigned RANDOM_PROBES  = 600;

  typedef struct {
    logic [SEC_BITS-1:0]   send_s;
    logic [MICRO_BITS-1:0] send_us;
    logic [SEC_BITS-1:0]   remote_s;
    logic [MICRO_BITS-1:0] remote_us;
    logic [SEC_BITS-1:0]   arrival_s;
    logic [MICRO_BITS-1:0] arrival_us;
  } probe_t;

  typedef struct {
    logic [OUT_BITS-1:0]  round_trip;
    logic [OUT_BITS-1:0]  forward;
    logic [OUT_BITS-1:0]  reverse;
    logic [OUT_BITS-1:0]  median;
    logic [HELD_BITS-1:0] held;
    logic                 full;
    logic                 clipped;
  } delay_report_t;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [SEC_BITS-1:0]   send_seconds_i = '0;
  logic [MICRO_BITS-1:0] send_micros_i = '0;
  logic [SEC_BITS-1:0]   remote_seconds_i = '0;
  logic [MICRO_BITS-1:0] remote_micros_i = '0;
  logic [SEC_BITS-1:0]   arrival_seconds_i = '0;
  logic [MICRO_BITS-1:0] arrival_micros_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [OUT_BITS-1:0]   round_trip_us_o;
  logic [OUT_BITS-1:0]   forward_us_o;
  logic [OUT_BITS-1:0]   reverse_us_o;
  logic [OUT_BITS-1:0]   median_forward_us_o;
  logic [HELD_BITS-1:0]  samples_held_o;
  logic                  window_full_o;
  logic                  saturated_o;

  logic                  no_stall = 1'b0;
  delay_report_t         expected_reports[$];
  int unsigned           mismatch_count = 0;

  // Predictor state: the forward delays of the current window.
  logic [63:0]           window_forward[WINDOW_SAMPLES];
  int unsigned           window_count = 0;

  one_way_delay_median_estimator_top #(
    .WINDOW_SAMPLES(WINDOW_SAMPLES),
    .DELAY_BITS    (DELAY_BITS)
  ) u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .send_seconds_i     (send_seconds_i),
    .send_micros_i      (send_micros_i),
    .remote_seconds_i   (remote_seconds_i),
    .remote_micros_i    (remote_micros_i),
    .arrival_seconds_i  (arrival_seconds_i),
    .arrival_micros_i   (arrival_micros_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .round_trip_us_o    (round_trip_us_o),
    .forward_us_o       (forward_us_o),
    .reverse_us_o       (reverse_us_o),
    .median_forward_us_o(median_forward_us_o),
    .samples_held_o     (samples_held_o),
    .window_full_o      (window_full_o),
    .saturated_o        (saturated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk_i) begin
    out_ready_i <= no_stall || ($urandom_range(0, 99) >= 19);
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [63:0] stamp_us(logic [SEC_BITS-1:0] s,
                                           logic [MICRO_BITS-1:0] us);
    return 64'(s) * 64'(US_PER_SEC) + 64'(us);
  endfunction

  function automatic logic [63:0] clipped_gap(logic [63:0] a, logic [63:0] b,
                                              inout logic clip);
    logic [63:0] d;
    d = (a >= b) ? a - b : b - a;
    if (d > DELAY_MAX) begin
      clip = 1'b1;
      d = DELAY_MAX;
    end
    return d;
  endfunction

  function automatic logic [63:0] window_median(int unsigned n);
    logic [63:0] sorted[WINDOW_SAMPLES];
    logic [63:0] v;
    int unsigned j;
    for (int unsigned i = 0; i < n; i++) begin
      v = window_forward[i];
      j = i;
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end
    return sorted[(n - 1) / 2];
  endfunction

  // Works out the report for one accepted probe and advances the window.
  function automatic delay_report_t predict_delays(probe_t p);
    delay_report_t r;
    logic        clip;
    logic [63:0] t_send, t_remote, t_arrival, rtt, fwd, rev, total, med;
    clip      = 1'b0;
    t_send    = stamp_us(p.send_s, p.send_us);
    t_remote  = stamp_us(p.remote_s, p.remote_us);
    t_arrival = stamp_us(p.arrival_s, p.arrival_us);
    rtt       = clipped_gap(t_arrival, t_send, clip);
    fwd       = clipped_gap(t_remote, t_send, clip);
    rev       = clipped_gap(t_arrival, t_remote, clip);
    total     = fwd + rev;
    if (total > rtt) begin
      fwd = 64'((128'(fwd) * 128'(rtt)) / 128'(total));
      rev = 64'((128'(rev) * 128'(rtt)) / 128'(total));
    end
    if (window_count >= WINDOW_SAMPLES) window_count = 0;
    window_forward[window_count] = fwd;
    window_count++;
    med          = window_median(window_count);
    r.round_trip = rtt[OUT_BITS-1:0];
    r.forward    = fwd[OUT_BITS-1:0];
    r.reverse    = rev[OUT_BITS-1:0];
    r.median     = med[OUT_BITS-1:0];
    r.held       = HELD_BITS'(window_count);
    r.full       = (window_count >= WINDOW_SAMPLES);
    r.clipped    = clip;
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("%0t: %s got %0d, expected %0d", $time, field, got, want);
  endtask

  always @(posedge clk_i) begin
    delay_report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_reports.size() == 0) begin
        report_mismatch("unexpected report, round_trip_us", round_trip_us_o, 0);
      end else begin
        want = expected_reports.pop_front();
        if (round_trip_us_o !== want.round_trip)
          report_mismatch("round_trip_us", round_trip_us_o, want.round_trip);
        if (forward_us_o !== want.forward)
          report_mismatch("forward_us", forward_us_o, want.forward);
        if (reverse_us_o !== want.reverse)
          report_mismatch("reverse_us", reverse_us_o, want.reverse);
        if (median_forward_us_o !== want.median)
          report_mismatch("median_forward_us", median_forward_us_o, want.median);
        if (samples_held_o !== want.held)
          report_mismatch("samples_held", samples_held_o, want.held);
        if (window_full_o !== want.full)
          report_mismatch("window_full", window_full_o, want.full);
        if (saturated_o !== want.clipped)
          report_mismatch("saturated", saturated_o, want.clipped);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic probe_t make_probe(logic [63:0] t_send, logic [63:0] t_remote,
                                        logic [63:0] t_arrival);
    probe_t p;
    p.send_s     = SEC_BITS'(t_send / US_PER_SEC);
    p.send_us    = MICRO_BITS'(t_send % US_PER_SEC);
    p.remote_s   = SEC_BITS'(t_remote / US_PER_SEC);
    p.remote_us  = MICRO_BITS'(t_remote % US_PER_SEC);
    p.arrival_s  = SEC_BITS'(t_arrival / US_PER_SEC);
    p.arrival_us = MICRO_BITS'(t_arrival % US_PER_SEC);
    return p;
  endfunction

  function automatic probe_t raw_probe(logic [31:0] ss, logic [19:0] su, logic [31:0] rs,
                                       logic [19:0] ru, logic [31:0] as, logic [19:0] au);
    probe_t p;
    p.send_s    = ss;
    p.send_us   = su;
    p.remote_s  = rs;
    p.remote_us = ru;
    p.arrival_s = as;
    p.arrival_us = au;
    return p;
  endfunction

  // Called at a rising edge; returns at the edge where the item was taken,
  // with valid still high.
  task automatic send_probe(probe_t p);
    while (!no_stall && $urandom_range(0, 99) < 19) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    send_seconds_i    <= p.send_s;
    send_micros_i     <= p.send_us;
    remote_seconds_i  <= p.remote_s;
    remote_micros_i   <= p.remote_us;
    arrival_seconds_i <= p.arrival_s;
    arrival_micros_i  <= p.arrival_us;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_reports.push_back(predict_delays(p));
  endtask

  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_timestamp_extremes();
    send_probe(raw_probe('0, '0, '0, '0, '0, '0));
    send_probe(raw_probe('1, '1, '1, '1, '1, '1));
    send_probe(raw_probe('0, '0, '0, '0, '1, '1));
    send_probe(raw_probe('1, '1, '0, '0, '0, '0));
    // Microsecond parts past one million are added without a carry.
    send_probe(raw_probe(32'd5, 20'd999999, 32'd5, '1, 32'd6, '0));
    send_probe(raw_probe(32'hAAAA_AAAA, 20'hAAAAA, 32'h5555_5555, 20'h55555,
                         32'hAAAA_AAAA, 20'h55555));
  endtask

  task automatic test_drift_cases();
    // Zero round trip with nonzero one-way delays collapses both to zero.
    send_probe(make_probe(64'd100000000, 64'd100000500, 64'd100000000));
    // Consistent timestamps: the sum equals the round trip, no scaling.
    send_probe(make_probe(64'd10000000, 64'd10000300, 64'd10001000));
    // Remote clock behind the send time.
    send_probe(make_probe(64'd10000500, 64'd10000100, 64'd10000900));
    // Remote clock ahead of the arrival time.
    send_probe(make_probe(64'd20000000, 64'd20007000, 64'd20001234));
    // Arrival before send.
    send_probe(make_probe(64'd30005000, 64'd30002000, 64'd30000000));
    // Forward and reverse saturate while the round trip does not.
    send_probe(raw_probe('0, '0, 32'd5000, '0, '0, 20'd10));
    wait_until_drained();
  endtask

  task automatic test_window_rollover();
    logic [63:0] fwd_list[12] = '{64'd700, 64'd50, 64'd900, 64'd50, 64'd0, 64'd333,
                                  64'd12000, 64'd1, 64'd450, 64'd999999,
                                  64'd80, 64'd4};
    logic [63:0] base;
    // Align to a fresh window so both rollovers land inside this run.
    while (window_count != WINDOW_SAMPLES && window_count != 0) begin
      base = 64'($urandom_range(1, 100000)) * US_PER_SEC;
      send_probe(make_probe(base, base + 64'd20, base + 64'd30));
    end
    foreach (fwd_list[i]) begin
      base = 64'd1000000 * (i + 1);
      send_probe(make_probe(base, base + fwd_list[i], base + fwd_list[i] + 64'd10));
    end
    wait_until_drained();
  endtask

  function automatic logic [63:0] random_delay();
    if ($urandom_range(0, 3) == 0) return 64'($urandom) * $urandom_range(1, 3);
    return 64'($urandom_range(0, 500000));
  endfunction

  task automatic test_random_probes(int unsigned count);
    logic [63:0] t_send, t_remote, t_arrival, skew;
    int unsigned kind;
    for (int unsigned n = 0; n < count; n++) begin
      no_stall <= (n >= 200 && n < 300);
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        send_probe(raw_probe($urandom, 20'($urandom_range(0, 20'hFFFFF)), $urandom,
                             20'($urandom_range(0, 20'hFFFFF)), $urandom,
                             20'($urandom_range(0, 20'hFFFFF))));
      end else begin
        t_send    = stamp_us($urandom, 20'($urandom_range(0, 999999)));
        t_remote  = t_send + random_delay();
        t_arrival = t_remote + random_delay();
        if (kind < 40) begin
          // Skewed remote clock.
          skew = 64'($urandom_range(0, 200000));
          if ($urandom_range(0, 1)) t_remote = t_remote + skew;
          else t_remote = (t_remote > skew) ? t_remote - skew : 64'd0;
        end
        send_probe(make_probe(t_send, t_remote, t_arrival));
      end
      if (n == 400) wait_until_drained();
    end
    no_stall <= 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_timestamp_extremes();
    test_drift_cases();
    test_window_rollover();
    test_random_probes(RANDOM_PROBES);
    wait_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
